@@ src/hftp_pkg.sv @@
// Shared types and request codes for the hex facing turn profiler.
`timescale 1ns / 1ps

package hftp_pkg;

    localparam int HEADING_W = 15;
    localparam int SPEED_W   = 16;
    localparam int COUNT_W   = 16;
    localparam int FACING_W  = 3;
    localparam int CFG_W     = 15;

    localparam logic [FACING_W-1:0] NUM_FACINGS = 3'd6;

    localparam logic [1:0] REQ_ADVANCE = 2'd0;
    localparam logic [1:0] REQ_START   = 2'd1;
    localparam logic [1:0] REQ_RESET   = 2'd2;

    localparam logic CFG_IDX_TURN_POWER = 1'b0;
    localparam logic CFG_IDX_MAX_SPEED  = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [HEADING_W-1:0] start_angle;
        logic                ccw_dir;
        logic [COUNT_W-1:0]  turn_count;
        logic [FACING_W-1:0] reset_facing;
    } item_t;

    typedef struct packed {
        logic [HEADING_W-1:0]      heading;
        logic signed [SPEED_W-1:0] speed;
        logic [FACING_W-1:0]       target_facing;
        logic                      turning;
        logic                      arrived;
    } res_t;

    typedef struct packed {
        logic [CFG_W-1:0] turn_power;
        logic [CFG_W-1:0] max_speed;
    } cfg_t;

endpackage

@@ src/hftp_mod.sv @@
// Remainder of an unsigned value by a constant, by reciprocal multiply and one correction.
`timescale 1ns / 1ps

module hftp_mod #(
    parameter int IN_W  = 16,
    parameter int MOD   = 6,
    parameter int OUT_W = 3
) (
    input  logic [IN_W-1:0]  x,
    output logic [OUT_W-1:0] rem
);
    localparam int SH = IN_W;
    localparam int MW = IN_W + 1;
    localparam int PW = IN_W + OUT_W + 1;
    localparam logic [MW-1:0] RECIP = MW'((longint'(1) << SH) / MOD);
    localparam logic [PW-1:0] MOD_C = PW'(MOD);

    logic [IN_W+MW-1:0] prod;
    logic [IN_W-1:0]    q_est;
    logic [PW-1:0]      rem_raw;
    logic [PW-1:0]      rem_fix;

    // quotient estimate is exact or one short
    assign prod    = {{MW{1'b0}}, x} * {{IN_W{1'b0}}, RECIP};
    assign q_est   = prod[SH +: IN_W];
    assign rem_raw = PW'(x) - PW'(q_est) * MOD_C;
    assign rem_fix = (rem_raw >= MOD_C) ? (rem_raw - MOD_C) : rem_raw;
    assign rem     = rem_fix[OUT_W-1:0];

endmodule

@@ src/hftp_core.sv @@
// Turn state and the single-pass next-state logic for one item.
`timescale 1ns / 1ps

module hftp_core #(
    parameter int SIXTH_TURN = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  hftp_pkg::item_t item,
    input  hftp_pkg::cfg_t  cfg,
    output hftp_pkg::res_t  res
);
    import hftp_pkg::*;

    localparam int FT    = 6 * SIXTH_TURN;
    localparam int ANG_W = $clog2(FT);
    localparam int DW    = COUNT_W + $clog2(SIXTH_TURN + 1) + 1;
    localparam int OFS   = FT * ((32768 + FT - 1) / FT);
    localparam int YW    = $clog2(2 * FT + 65536);
    localparam logic [ANG_W-1:0] SIXTH_C = ANG_W'(SIXTH_TURN);

    logic [ANG_W-1:0]          angle_reg, angle_next;
    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic [DW-1:0]             turned_reg, turned_next;
    logic [DW-1:0]             wanted_reg, wanted_next;
    logic [DW-1:0]             decel_reg, decel_next;
    logic [FACING_W-1:0]       goal_reg, goal_next;
    logic                      arrived;

    logic [ANG_W-1:0]    start_wrap;
    logic [FACING_W-1:0] count_mod6;
    logic [YW-1:0]       adv_sum;
    logic [ANG_W-1:0]    adv_wrap;
    logic [ANG_W+14:0]   angle_ext;

    hftp_mod #(.IN_W(HEADING_W), .MOD(FT), .OUT_W(ANG_W)) u_start_wrap (
        .x   (item.start_angle),
        .rem (start_wrap)
    );

    hftp_mod #(.IN_W(COUNT_W), .MOD(6), .OUT_W(FACING_W)) u_count_mod (
        .x   (item.turn_count),
        .rem (count_mod6)
    );

    // bias by whole turns so the sum stays positive before the remainder
    assign adv_sum = YW'(angle_reg) + YW'(OFS)
                   + {{(YW-SPEED_W){speed_reg[SPEED_W-1]}}, speed_reg};

    hftp_mod #(.IN_W(YW), .MOD(FT), .OUT_W(ANG_W)) u_adv_wrap (
        .x   (adv_sum),
        .rem (adv_wrap)
    );

    always_comb begin
        logic                neg;
        logic [CFG_W-1:0]    mag;
        logic [CFG_W-1:0]    new_mag;
        logic [SPEED_W-1:0]  mag_dec;
        logic [SPEED_W-1:0]  mag_inc;
        logic [DW-1:0]       td1;
        logic [FACING_W-1:0] fac;
        logic [FACING_W:0]   turns;
        logic [FACING_W:0]   goal_sum;
        logic [FACING_W-1:0] rst_fac;

        angle_next  = angle_reg;
        speed_next  = speed_reg;
        turned_next = turned_reg;
        wanted_next = wanted_reg;
        decel_next  = decel_reg;
        goal_next   = goal_reg;
        arrived     = 1'b0;

        neg     = speed_reg[SPEED_W-1];
        mag     = neg ? CFG_W'(-speed_reg) : CFG_W'(speed_reg);
        new_mag = mag;
        mag_dec = {1'b0, mag} - {1'b0, cfg.turn_power};
        mag_inc = {1'b0, mag} + {1'b0, cfg.turn_power};
        td1     = turned_reg + DW'(mag);

        fac = '0;
        for (int k = 1; k < 6; k++) begin
            if (start_wrap >= ANG_W'(k * SIXTH_TURN)) begin
                fac = FACING_W'(k);
            end
        end
        turns    = item.ccw_dir ? ({1'b0, NUM_FACINGS} - {1'b0, count_mod6})
                                : {1'b0, count_mod6};
        goal_sum = {1'b0, fac} + turns;
        rst_fac  = (item.reset_facing >= NUM_FACINGS) ? (item.reset_facing - NUM_FACINGS)
                                                      : item.reset_facing;

        case (item.req_type)
            REQ_ADVANCE: begin
                if (speed_reg != '0) begin
                    turned_next = td1;
                    angle_next  = adv_wrap;
                    if (td1 >= wanted_reg) begin
                        angle_next = ANG_W'(goal_reg) * SIXTH_C;
                        speed_next = '0;
                        arrived    = 1'b1;
                    end else if (td1 >= decel_reg ||
                                 (decel_reg == wanted_reg && td1 >= (wanted_reg >> 1))) begin
                        if (decel_reg == wanted_reg) begin
                            decel_next = wanted_reg >> 1;
                        end else begin
                            // slow down by the turn power; a speed at or below the turn power is held there
                            new_mag = (mag <= cfg.turn_power) ? cfg.turn_power
                                                              : mag_dec[CFG_W-1:0];
                            speed_next = neg ? -$signed({1'b0, new_mag})
                                             : $signed({1'b0, new_mag});
                        end
                    end else begin
                        new_mag = (mag_inc > {1'b0, cfg.max_speed}) ? cfg.max_speed
                                                                    : mag_inc[CFG_W-1:0];
                        speed_next = neg ? -$signed({1'b0, new_mag})
                                         : $signed({1'b0, new_mag});
                        if (mag < cfg.max_speed && new_mag == cfg.max_speed) begin
                            decel_next = wanted_reg - td1;
                        end
                    end
                end
            end
            REQ_START: begin
                if (speed_reg == '0) begin
                    angle_next = start_wrap;
                    if (item.turn_count != '0) begin
                        wanted_next = DW'(item.turn_count) * DW'(SIXTH_TURN);
                        turned_next = '0;
                        decel_next  = DW'(item.turn_count) * DW'(SIXTH_TURN);
                        speed_next  = item.ccw_dir ? -$signed({1'b0, cfg.turn_power})
                                                   : $signed({1'b0, cfg.turn_power});
                        goal_next   = (goal_sum >= {1'b0, NUM_FACINGS})
                                    ? FACING_W'(goal_sum - {1'b0, NUM_FACINGS})
                                    : FACING_W'(goal_sum);
                    end
                end
            end
            REQ_RESET: begin
                wanted_next = '0;
                turned_next = '0;
                decel_next  = '0;
                goal_next   = rst_fac;
                angle_next  = ANG_W'(rst_fac) * SIXTH_C;
                speed_next  = '0;
            end
            default: begin
            end
        endcase
    end

    assign angle_ext = (ANG_W + 15)'(angle_next);

    always_comb begin
        res.heading       = angle_ext[HEADING_W-1:0];
        res.speed         = speed_next;
        res.target_facing = goal_next;
        res.turning       = (speed_next != '0);
        res.arrived       = arrived;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg  <= '0;
            speed_reg  <= '0;
            turned_reg <= '0;
            wanted_reg <= '0;
            decel_reg  <= '0;
            goal_reg   <= '0;
        end else if (fire) begin
            angle_reg  <= angle_next;
            speed_reg  <= speed_next;
            turned_reg <= turned_next;
            wanted_reg <= wanted_next;
            decel_reg  <= decel_next;
            goal_reg   <= goal_next;
        end
    end

endmodule

@@ src/hex_facing_turn_profiler.sv @@
// Top level of the hex facing turn profiler: item and result registers, config registers.
// Takes one request item per cycle unless the result side stalls (advance a frame, start a
// turn, reset to a facing) and returns one result item for each. Sustained rate is one item
// per clock while m_tready stays high; an accepted item passes the input register, then the
// result register, before its result is on m_tdata, and a stalled result holds the next item
// in the input register. The rate is set by the state feedback loop, where angle wrap, distance
// compare and speed clamp for one item are combinational and finish before the next item reads
// the updated state. Write turn_power and max_speed only while no item is in flight.
`timescale 1ns / 1ps

module hex_facing_turn_profiler #(
    parameter int SIXTH_TURN = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // start_angle[14:0], ccw_dir, turn_count[15:0], reset_facing[2:0]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // heading[14:0], speed[15:0], target_facing[2:0], turning, arrived
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_wdata
);
    import hftp_pkg::*;

    item_t item_reg;
    logic  in_valid_reg, in_valid_next;
    res_t  out_reg;
    res_t  res;
    logic  out_valid_reg, out_valid_next;
    cfg_t  cfg_reg;
    logic  in_take;
    logic  fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                if (cfg_index == CFG_IDX_TURN_POWER) begin
                    cfg_reg.turn_power <= cfg_wdata;
                end
                if (cfg_index == CFG_IDX_MAX_SPEED) begin
                    cfg_reg.max_speed <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            item_reg.req_type     <= s_tuser;
            item_reg.start_angle  <= s_tdata[14:0];
            item_reg.ccw_dir      <= s_tdata[15];
            item_reg.turn_count   <= s_tdata[31:16];
            item_reg.reset_facing <= s_tdata[34:32];
        end
        if (fire) begin
            out_reg <= res;
        end
    end

    hftp_core #(.SIXTH_TURN(SIXTH_TURN)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.arrived, out_reg.turning, out_reg.target_facing,
                       out_reg.speed, out_reg.heading};

`ifndef SYNTH
    a_arrive_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_reg.arrived && out_reg.turning))
        else $error("arrived result still shows turning");

    a_turning_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.turning == (out_reg.speed != '0)))
        else $error("turning flag disagrees with speed");

    a_goal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.target_facing < NUM_FACINGS))
        else $error("target facing out of range");

    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("stalled item dropped from input register");
`endif

endmodule

@@ bench/hex_facing_turn_profiler_tb.sv @@
// Self-checking testbench for the hex facing turn profiler: predicts every result item.
`timescale 1ns / 1ps

module hex_facing_turn_profiler_tb;
    import hftp_pkg::*;

    localparam int SIXTH_TURN = 4096;
    localparam int FULL_TURN  = 6 * SIXTH_TURN;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // start_angle[14:0], ccw_dir, turn_count[15:0], reset_facing[2:0]
    logic [1:0]  s_tuser = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;        // heading[14:0], speed[15:0], target_facing[2:0], turning, arrived
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [14:0] cfg_wdata = '0;

    hex_facing_turn_profiler #(
        .SIXTH_TURN(SIXTH_TURN)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Profiler state as the block should hold it.
    logic [14:0]        hdg_st = '0;
    logic signed [15:0] spd_st = '0;
    logic [29:0]        done_dist = '0;
    logic [29:0]        goal_dist = '0;
    logic [29:0]        brake_mark = '0;
    logic [2:0]         face_goal = '0;
    logic [14:0]        pwr_cfg = '0;
    logic [14:0]        vmax_cfg = '0;

    res_t expected_results[$];
    bit   idle_on = 1'b1;
    int   items_sent = 0;
    int   results_seen = 0;
    int   arrivals_seen = 0;
    int   settings_used = 0;
    int   bad_count = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("hex_facing_turn_profiler_tb: errors");
        $finish;
    end

    // Advance the predicted state by one request item and return its result item.
    function automatic res_t profile_step(input item_t it);
        res_t r;
        int   sp, old, p, m, a, fac, turns, f;
        logic hit;
        hit = 1'b0;
        p = int'(pwr_cfg);
        m = int'(vmax_cfg);
        case (it.req_type)
            REQ_ADVANCE: begin
                if (spd_st != 0) begin
                    sp = spd_st;
                    done_dist = done_dist + 30'(sp < 0 ? -sp : sp);
                    a = (int'(hdg_st) + sp) % FULL_TURN;
                    if (a < 0) a += FULL_TURN;
                    hdg_st = 15'(a);
                    if (done_dist >= goal_dist) begin
                        // snap to the goal facing and stop
                        hdg_st = 15'(int'(face_goal) * SIXTH_TURN);
                        sp = 0;
                        hit = 1'b1;
                    end else if (done_dist >= brake_mark ||
                                 (brake_mark == goal_dist && done_dist >= (goal_dist >> 1))) begin
                        if (brake_mark == goal_dist) begin
                            brake_mark = goal_dist >> 1;
                        end else if (sp > 0) begin
                            sp -= p;
                            if (sp <= 0) sp = p;
                        end else begin
                            sp += p;
                            if (sp >= 0) sp = -p;
                        end
                    end else begin
                        old = sp;
                        if (sp > 0) begin
                            sp += p;
                            if (sp > m) sp = m;
                            if (old < m && sp == m) brake_mark = goal_dist - done_dist;
                        end else begin
                            sp -= p;
                            if (sp < -m) sp = -m;
                            if (old > -m && sp == -m) brake_mark = goal_dist - done_dist;
                        end
                    end
                    spd_st = 16'(sp);
                end
            end
            REQ_START: begin
                // a start while turning is dropped
                if (spd_st == 0) begin
                    a = int'(it.start_angle) % FULL_TURN;
                    hdg_st = 15'(a);
                    if (it.turn_count != 0) begin
                        goal_dist = 30'(int'(it.turn_count) * SIXTH_TURN);
                        done_dist = '0;
                        brake_mark = goal_dist;
                        fac = (a / SIXTH_TURN) % 6;
                        if (it.ccw_dir) begin
                            turns = 6 - int'(it.turn_count) % 6;
                            spd_st = 16'(-p);
                        end else begin
                            turns = int'(it.turn_count) % 6;
                            spd_st = 16'(p);
                        end
                        face_goal = 3'((fac + turns) % 6);
                    end
                end
            end
            REQ_RESET: begin
                f = int'(it.reset_facing) % 6;
                goal_dist = '0;
                done_dist = '0;
                brake_mark = '0;
                face_goal = 3'(f);
                hdg_st = 15'(f * SIXTH_TURN);
                spd_st = '0;
            end
            default: ;
        endcase
        r.heading = hdg_st;
        r.speed = spd_st;
        r.target_facing = face_goal;
        r.turning = (spd_st != 0);
        r.arrived = hit;
        return r;
    endfunction

    function automatic item_t any_item(input logic [1:0] req);
        item_t it;
        it.req_type = req;
        it.start_angle = 15'($urandom_range(0, 32767));
        it.ccw_dir = 1'($urandom_range(0, 1));
        it.turn_count = 16'($urandom_range(0, 65535));
        it.reset_facing = 3'($urandom_range(0, 7));
        return it;
    endfunction

    // Mostly short turns that finish, now and then long or empty ones.
    function automatic logic [15:0] random_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 6) return 16'($urandom_range(1, 6));
        if (pick == 7) return 16'($urandom_range(7, 24));
        if (pick == 8) return 16'd0;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_request(input item_t it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.req_type;
        s_tdata <= {5'd0, it.reset_facing, it.turn_count, it.ccw_dir, it.start_angle};
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_results.push_back(profile_step(it));
        items_sent++;
    endtask

    task automatic send_fields(input logic [1:0] req, input logic [14:0] angle,
                               input logic ccw, input logic [15:0] count,
                               input logic [2:0] facing);
        item_t it;
        it.req_type = req;
        it.start_angle = angle;
        it.ccw_dir = ccw;
        it.turn_count = count;
        it.reset_facing = facing;
        send_request(it);
    endtask

    task automatic advance_to_rest(input int cap);
        while (spd_st != 0 && cap > 0) begin
            send_request(any_item(REQ_ADVANCE));
            cap--;
        end
    endtask

    // Hold the sender until every result is back, then write both limits.
    task automatic set_limits(input logic [14:0] p, input logic [14:0] m);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_TURN_POWER;
        cfg_wdata <= p;
        @(posedge aclk);
        cfg_index <= CFG_IDX_MAX_SPEED;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pwr_cfg = p;
        vmax_cfg = m;
        settings_used++;
    endtask

    task automatic random_limits();
        int p, m;
        p = $urandom_range(200, 4000);
        if ($urandom_range(0, 3) == 0) m = $urandom_range(0, 24575);
        else m = $urandom_range(p, 12000);
        set_limits(15'(p), 15'(m));
    endtask

    // Well-formed turns with random content, mixed with stray and broken requests.
    task automatic turn_session(input int budget);
        int stop_at, frames;
        item_t it;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) begin
                send_request(any_item(2'($urandom_range(0, 3))));
            end else begin
                if (spd_st != 0 ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 2) == 0))
                    send_request(any_item(REQ_RESET));
                it = any_item(REQ_START);
                it.turn_count = random_count();
                send_request(it);
                frames = $urandom_range(8, 64);
                while (spd_st != 0 && frames > 0) begin
                    if ($urandom_range(0, 19) == 0)
                        send_request(any_item($urandom_range(0, 1) ? REQ_START : REQ_UNUSED));
                    send_request(any_item(REQ_ADVANCE));
                    frames--;
                end
                repeat ($urandom_range(0, 2)) send_request(any_item(REQ_ADVANCE));
            end
        end
    endtask

    // Limits still at zero: nothing may move.
    task automatic test_reset_state();
        send_request(any_item(REQ_ADVANCE));
        send_request(any_item(REQ_UNUSED));
        send_fields(REQ_START, 15'h7fff, 1'b1, 16'hffff, 3'd0);
        send_request(any_item(REQ_ADVANCE));
        send_fields(REQ_RESET, 15'd0, 1'b0, 16'd0, 3'd7);
    endtask

    task automatic test_directed_turns();
        set_limits(15'd1024, 15'd4096);
        send_fields(REQ_RESET, 15'd0, 1'b0, 16'd0, 3'd6);
        send_fields(REQ_START, 15'd0, 1'b0, 16'd1, 3'd0);
        advance_to_rest(8);
        send_fields(REQ_ADVANCE, 15'd0, 1'b0, 16'd0, 3'd0);
        send_fields(REQ_START, 15'd24575, 1'b1, 16'd2, 3'd0);
        send_fields(REQ_START, 15'd100, 1'b0, 16'd5, 3'd0);
        send_request(any_item(REQ_UNUSED));
        advance_to_rest(12);
        send_fields(REQ_START, 15'd12345, 1'b0, 16'd0, 3'd0);
        send_fields(REQ_RESET, 15'd0, 1'b0, 16'd0, 3'd5);
    endtask

    // Speed up to just under a full turn, zero and tiny limits, max below power.
    task automatic test_extreme_limits();
        set_limits(15'd24575, 15'd24575);
        turn_session(40);
        set_limits(15'd1, 15'd0);
        turn_session(40);
        set_limits(15'd5000, 15'd100);
        turn_session(40);
        set_limits(15'd0, 15'd24575);
        turn_session(40);
        set_limits(15'd24575, 15'd1);
        turn_session(40);
    endtask

    task automatic test_random_turns();
        repeat (6) begin
            random_limits();
            turn_session(140);
        end
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        random_limits();
        turn_session(220);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.heading = m_tdata[14:0];
            got.speed = m_tdata[30:15];
            got.target_facing = m_tdata[33:31];
            got.turning = m_tdata[34];
            got.arrived = m_tdata[35];
            results_seen++;
            if (expected_results.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected result: heading %0d speed %0d facing %0d",
                             got.heading, got.speed, got.target_facing);
            end else begin
                want = expected_results.pop_front();
                if (want.arrived) arrivals_seen++;
                if (got.heading !== want.heading || got.speed !== want.speed ||
                    got.target_facing !== want.target_facing ||
                    got.turning !== want.turning || got.arrived !== want.arrived) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display({"result %0d (expected/actual): heading %0d/%0d ",
                                  "speed %0d/%0d facing %0d/%0d turning %0b/%0b arrived %0b/%0b"},
                                 results_seen, want.heading, got.heading, want.speed, got.speed,
                                 want.target_facing, got.target_facing, want.turning,
                                 got.turning, want.arrived, got.arrived);
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed_turns();
        test_extreme_limits();
        test_random_turns();
        test_full_rate();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("sent %0d requests under %0d limit settings", items_sent, settings_used);
        $display("checked %0d results, %0d turns reached their facing, %0d mismatches",
                 results_seen, arrivals_seen, bad_count);
        if (bad_count == 0)
            $display("hex_facing_turn_profiler_tb: clean");
        else
            $display("hex_facing_turn_profiler_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
src/hftp_pkg.sv
src/hftp_mod.sv
src/hftp_core.sv
src/hex_facing_turn_profiler.sv
bench/hex_facing_turn_profiler_tb.sv
